// File: design/chained_hash_map_engine_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the chained hash map engine
// Shorthand for clocked implication checks, reset-qualified.
// ---------------------------------------------------------------------------
`ifndef CHAINED_HASH_MAP_ENGINE_MACROS_SVH
`define CHAINED_HASH_MAP_ENGINE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CHM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CHM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/chm_pkg.sv
// ---------------------------------------------------------------------------
// chm_pkg
// Shared types, beat layouts and default sizes of the chained hash map engine.
// ---------------------------------------------------------------------------
`default_nettype none

package chm_pkg;

  localparam int CHM_BUCKETS    = 16;
  localparam int CHM_NODES      = 64;
  localparam int CHM_KEY_BITS   = 32;
  localparam int CHM_VALUE_BITS = 32;

  localparam int DATA_W  = 32;
  localparam int COUNT_W = 7;

  // Input beat: tuser holds the operation kind, tdata hash, key, value.
  localparam int IN_TUSER_W   = 3;
  localparam int IN_HASH_LSB  = 0;
  localparam int IN_KEY_LSB   = 32;
  localparam int IN_VALUE_LSB = 64;
  localparam int IN_TDATA_W   = 96;

  // Result beat: found, previous value, entry count, full flag.
  localparam int OUT_FOUND_LSB = 0;
  localparam int OUT_PREV_LSB  = 1;
  localparam int OUT_COUNT_LSB = 33;
  localparam int OUT_FULL_LSB  = 40;
  localparam int OUT_TDATA_W   = 48;

  typedef enum logic [2:0] {
    OP_PUT         = 3'd0,
    OP_PUT_ABSENT  = 3'd1,
    OP_GET         = 3'd2,
    OP_REMOVE      = 3'd3,
    OP_REPLACE     = 3'd4,
    OP_CLEAR       = 3'd5
  } op_kind_t;

  typedef enum logic [3:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_HEAD,
    ST_WALK,
    ST_DECIDE,
    ST_ALLOC,
    ST_LINK,
    ST_UNLINK,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

// File: design/chm_ram.sv
// ---------------------------------------------------------------------------
// chm_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module chm_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: design/chm_ctrl.sv
// ---------------------------------------------------------------------------
// chm_ctrl
// Request sequencer: bucket lookup, chain walk, node allocation and unlinking.
// ---------------------------------------------------------------------------
`default_nettype none

module chm_ctrl import chm_pkg::*; #(
  parameter int BUCKETS    = CHM_BUCKETS,
  parameter int NODES      = CHM_NODES,
  parameter int KEY_BITS   = CHM_KEY_BITS,
  parameter int VALUE_BITS = CHM_VALUE_BITS
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  input  wire logic [IN_TUSER_W-1:0]       in_tuser,
  input  wire logic [IN_TDATA_W-1:0]       in_tdata,
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  output logic      [OUT_TDATA_W-1:0]      out_tdata,
  output logic                             hd_we,
  output logic      [$clog2(BUCKETS)-1:0]  hd_waddr,
  output logic      [$clog2(NODES+1)-1:0]  hd_wdata,
  output logic      [$clog2(BUCKETS)-1:0]  hd_raddr,
  input  wire logic [$clog2(NODES+1)-1:0]  hd_rdata,
  output logic                             nd_we,
  output logic      [$clog2(NODES)-1:0]    nd_waddr,
  output logic      [DATA_W+KEY_BITS+VALUE_BITS+$clog2(NODES+1)-1:0] nd_wdata,
  output logic      [$clog2(NODES)-1:0]    nd_raddr,
  input  wire logic [DATA_W+KEY_BITS+VALUE_BITS+$clog2(NODES+1)-1:0] nd_rdata
);

  localparam int BW  = $clog2(BUCKETS);
  localparam int NIW = $clog2(NODES);
  localparam int LW  = $clog2(NODES + 1);
  localparam int NWW = DATA_W + KEY_BITS + VALUE_BITS + LW;
  localparam int VAL_LSB  = LW;
  localparam int KEY_LSB  = LW + VALUE_BITS;
  localparam int HASH_LSB = LW + VALUE_BITS + KEY_BITS;
  localparam logic [LW-1:0] NULL_LINK   = LW'(NODES);
  localparam logic [LW-1:0] LAST_STEP   = LW'(NODES - 1);
  localparam logic [BW-1:0] BUCKET_MASK = BW'(BUCKETS - 1);

  state_t                 state_r, state_nxt;
  op_kind_t               kind_r, kind_nxt;
  logic [DATA_W-1:0]      hash_r, hash_nxt;
  logic [KEY_BITS-1:0]    key_r, key_nxt;
  logic [VALUE_BITS-1:0]  val_r, val_nxt;
  logic [BW-1:0]          bucket_r, bucket_nxt;
  logic [LW-1:0]          cur_r, cur_nxt;
  logic [LW-1:0]          prev_r, prev_nxt;
  logic [NWW-1:0]         prev_data_r, prev_data_nxt;
  logic [LW-1:0]          hit_r, hit_nxt;
  logic [NWW-1:0]         hit_data_r, hit_data_nxt;
  logic                   found_r, found_nxt;
  logic                   full_r, full_nxt;
  logic [LW-1:0]          new_node_r, new_node_nxt;
  logic                   use_free_r, use_free_nxt;
  logic [LW-1:0]          steps_r, steps_nxt;
  logic [LW-1:0]          count_r, count_nxt;
  logic [LW-1:0]          fresh_r, fresh_nxt;
  logic [LW-1:0]          free_head_r, free_head_nxt;
  logic [BW-1:0]          sweep_r, sweep_nxt;
  logic                   sweep_rsp_r, sweep_rsp_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  op_kind_t               in_kind;
  logic [DATA_W-1:0]      in_hash;
  logic [BW-1:0]          in_bucket;
  logic                   accept;
  logic [LW-1:0]          rd_link;
  logic                   node_match;
  logic                   link_end;
  logic                   head_null;
  logic                   can_load;
  logic [OUT_TDATA_W-1:0] result_word;

  assign in_kind    = op_kind_t'(in_tuser);
  assign in_hash    = in_tdata[IN_HASH_LSB +: DATA_W];
  assign in_bucket  = in_hash[BW-1:0] & BUCKET_MASK;
  assign in_tready  = (state_r == ST_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign rd_link    = nd_rdata[LW-1:0];
  assign node_match = (nd_rdata[HASH_LSB +: DATA_W] == hash_r) &&
                      (nd_rdata[KEY_LSB +: KEY_BITS] == key_r);
  // A corrupt chain stops the walk after as many nodes as the pool holds.
  assign link_end   = (rd_link >= NULL_LINK) || (steps_r == LAST_STEP);
  assign head_null  = (hd_rdata >= NULL_LINK);
  assign can_load   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    result_word = '0;
    result_word[OUT_FOUND_LSB] = found_r;
    result_word[OUT_PREV_LSB +: DATA_W] =
      found_r ? DATA_W'(hit_data_r[VAL_LSB +: VALUE_BITS]) : '0;
    result_word[OUT_COUNT_LSB +: COUNT_W] = COUNT_W'(count_r);
    result_word[OUT_FULL_LSB] = full_r;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_SWEEP: begin
        if (sweep_r == BUCKET_MASK) begin
          state_nxt = sweep_rsp_r ? ST_DONE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_kind inside {[OP_PUT:OP_REPLACE]}) begin
            state_nxt = ST_HEAD;
          end else if (in_kind == OP_CLEAR) begin
            state_nxt = ST_SWEEP;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_HEAD: begin
        state_nxt = head_null ? ST_DECIDE : ST_WALK;
      end
      ST_WALK: begin
        if (node_match || link_end) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        state_nxt = ST_DONE;
        if (kind_r inside {OP_PUT, OP_PUT_ABSENT}) begin
          if (!found_r && (count_r != NULL_LINK)) begin
            state_nxt = ST_ALLOC;
          end
        end else if (kind_r == OP_REMOVE && found_r) begin
          state_nxt = ST_UNLINK;
        end
      end
      ST_ALLOC:  state_nxt = ST_LINK;
      ST_LINK:   state_nxt = ST_DONE;
      ST_UNLINK: state_nxt = ST_DONE;
      ST_DONE: begin
        if (can_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and memory ports.
  always_comb begin
    kind_nxt      = kind_r;
    hash_nxt      = hash_r;
    key_nxt       = key_r;
    val_nxt       = val_r;
    bucket_nxt    = bucket_r;
    cur_nxt       = cur_r;
    prev_nxt      = prev_r;
    prev_data_nxt = prev_data_r;
    hit_nxt       = hit_r;
    hit_data_nxt  = hit_data_r;
    found_nxt     = found_r;
    full_nxt      = full_r;
    new_node_nxt  = new_node_r;
    use_free_nxt  = use_free_r;
    steps_nxt     = steps_r;
    count_nxt     = count_r;
    fresh_nxt     = fresh_r;
    free_head_nxt = free_head_r;
    sweep_nxt     = sweep_r;
    sweep_rsp_nxt = sweep_rsp_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    hd_we         = 1'b0;
    hd_waddr      = bucket_r;
    hd_wdata      = NULL_LINK;
    hd_raddr      = in_bucket;
    nd_we         = 1'b0;
    nd_waddr      = hit_r[NIW-1:0];
    nd_wdata      = hit_data_r;
    nd_raddr      = cur_r[NIW-1:0];

    case (state_r)
      ST_SWEEP: begin
        hd_we     = 1'b1;
        hd_waddr  = sweep_r;
        sweep_nxt = sweep_r + BW'(1);
      end
      ST_IDLE: begin
        if (accept) begin
          kind_nxt   = in_kind;
          hash_nxt   = in_hash;
          key_nxt    = KEY_BITS'(in_tdata[IN_KEY_LSB +: DATA_W]);
          val_nxt    = VALUE_BITS'(in_tdata[IN_VALUE_LSB +: DATA_W]);
          bucket_nxt = in_bucket;
          prev_nxt   = NULL_LINK;
          hit_nxt    = NULL_LINK;
          found_nxt  = 1'b0;
          full_nxt   = 1'b0;
          steps_nxt  = '0;
          if (in_kind == OP_CLEAR) begin
            count_nxt     = '0;
            fresh_nxt     = '0;
            free_head_nxt = NULL_LINK;
            sweep_nxt     = '0;
            sweep_rsp_nxt = 1'b1;
          end
        end
      end
      ST_HEAD: begin
        cur_nxt  = hd_rdata;
        nd_raddr = hd_rdata[NIW-1:0];
      end
      ST_WALK: begin
        if (node_match) begin
          hit_nxt      = cur_r;
          hit_data_nxt = nd_rdata;
          found_nxt    = 1'b1;
        end else begin
          prev_nxt      = cur_r;
          prev_data_nxt = nd_rdata;
          steps_nxt     = steps_r + LW'(1);
          cur_nxt       = rd_link;
          nd_raddr      = rd_link[NIW-1:0];
        end
      end
      ST_DECIDE: begin
        nd_raddr = free_head_r[NIW-1:0];
        case (kind_r)
          OP_PUT, OP_PUT_ABSENT, OP_REPLACE: begin
            if (found_r) begin
              if (kind_r != OP_PUT_ABSENT) begin
                nd_we    = 1'b1;
                nd_wdata = {hit_data_r[NWW-1:KEY_LSB], val_r, hit_data_r[LW-1:0]};
              end
            end else if (kind_r != OP_REPLACE) begin
              if (count_r == NULL_LINK) begin
                full_nxt = 1'b1;
              end else if (fresh_r < NULL_LINK) begin
                new_node_nxt = fresh_r;
                fresh_nxt    = fresh_r + LW'(1);
                use_free_nxt = 1'b0;
              end else begin
                new_node_nxt = free_head_r;
                use_free_nxt = 1'b1;
              end
            end
          end
          OP_REMOVE: begin
            if (found_r) begin
              // The freed node joins the free list through its own link field.
              nd_we         = 1'b1;
              nd_wdata      = {hit_data_r[NWW-1:LW], free_head_r};
              free_head_nxt = hit_r;
              count_nxt     = count_r - LW'(1);
            end
          end
          default: begin
          end
        endcase
      end
      ST_ALLOC: begin
        nd_we     = 1'b1;
        nd_waddr  = new_node_r[NIW-1:0];
        nd_wdata  = {hash_r, key_r, val_r, NULL_LINK};
        count_nxt = count_r + LW'(1);
        if (use_free_r) begin
          free_head_nxt = rd_link;
        end
      end
      ST_LINK: begin
        if (prev_r == NULL_LINK) begin
          hd_we    = 1'b1;
          hd_wdata = new_node_r;
        end else begin
          nd_we    = 1'b1;
          nd_waddr = prev_r[NIW-1:0];
          nd_wdata = {prev_data_r[NWW-1:LW], new_node_r};
        end
      end
      ST_UNLINK: begin
        if (prev_r == NULL_LINK) begin
          hd_we    = 1'b1;
          hd_wdata = hit_data_r[LW-1:0];
        end else begin
          nd_we    = 1'b1;
          nd_waddr = prev_r[NIW-1:0];
          nd_wdata = {prev_data_r[NWW-1:LW], hit_data_r[LW-1:0]};
        end
      end
      ST_DONE: begin
        if (can_load) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = result_word;
          sweep_rsp_nxt = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SWEEP;
      count_r     <= '0;
      fresh_r     <= '0;
      free_head_r <= NULL_LINK;
      sweep_r     <= '0;
      sweep_rsp_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      fresh_r     <= fresh_nxt;
      free_head_r <= free_head_nxt;
      sweep_r     <= sweep_nxt;
      sweep_rsp_r <= sweep_rsp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r      <= kind_nxt;
    hash_r      <= hash_nxt;
    key_r       <= key_nxt;
    val_r       <= val_nxt;
    bucket_r    <= bucket_nxt;
    cur_r       <= cur_nxt;
    prev_r      <= prev_nxt;
    prev_data_r <= prev_data_nxt;
    hit_r       <= hit_nxt;
    hit_data_r  <= hit_data_nxt;
    found_r     <= found_nxt;
    full_r      <= full_nxt;
    new_node_r  <= new_node_nxt;
    use_free_r  <= use_free_nxt;
    steps_r     <= steps_nxt;
    out_data_r  <= out_data_nxt;
  end

endmodule

`default_nettype wire

// File: design/chained_hash_map_engine.sv
// ---------------------------------------------------------------------------
// chained_hash_map_engine
// Key-value store with separately chained buckets over a fixed node pool.
// ---------------------------------------------------------------------------
// Requests arrive as beats on the in_ channel: in_tuser carries the operation
// kind, in_tdata the hash, key and value. Every request gives exactly one
// result beat on the out_ channel (found, previous value, entry count, full).
// One request is in progress at a time. A lookup reads the bucket head, then
// one node of the chain per cycle from the node RAM, and an insert or a
// removal then writes the node RAM or the head RAM; the next request is
// taken the cycle after the result is registered. A clear rewrites every
// bucket head, one a cycle, and then gives its result beat. After reset
// the same sweep over the BUCKETS head entries runs before in_tready
// rises. The result sits in an output register: while the receiver stalls,
// the result beat is held, and the block holds back the next result but
// still accepts one new request.
// ---------------------------------------------------------------------------
`default_nettype none

module chained_hash_map_engine import chm_pkg::*; #(
  parameter int BUCKETS    = CHM_BUCKETS,
  parameter int NODES      = CHM_NODES,
  parameter int KEY_BITS   = CHM_KEY_BITS,
  parameter int VALUE_BITS = CHM_VALUE_BITS
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TUSER_W-1:0]  in_tuser,   // kind
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // hash_code, key_word, value_word
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic      [OUT_TDATA_W-1:0] out_tdata   // found, previous_value,
                                                  // entry_count, table_full, zeros
);

  localparam int BW  = $clog2(BUCKETS);
  localparam int NIW = $clog2(NODES);
  localparam int LW  = $clog2(NODES + 1);
  localparam int NWW = DATA_W + KEY_BITS + VALUE_BITS + LW;

  logic           hd_we;
  logic [BW-1:0]  hd_waddr;
  logic [LW-1:0]  hd_wdata;
  logic [BW-1:0]  hd_raddr;
  logic [LW-1:0]  hd_rdata;
  logic           nd_we;
  logic [NIW-1:0] nd_waddr;
  logic [NWW-1:0] nd_wdata;
  logic [NIW-1:0] nd_raddr;
  logic [NWW-1:0] nd_rdata;

  chm_ctrl #(
    .BUCKETS    (BUCKETS),
    .NODES      (NODES),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .hd_we      (hd_we),
    .hd_waddr   (hd_waddr),
    .hd_wdata   (hd_wdata),
    .hd_raddr   (hd_raddr),
    .hd_rdata   (hd_rdata),
    .nd_we      (nd_we),
    .nd_waddr   (nd_waddr),
    .nd_wdata   (nd_wdata),
    .nd_raddr   (nd_raddr),
    .nd_rdata   (nd_rdata)
  );

  chm_ram #(
    .DEPTH (BUCKETS),
    .WIDTH (LW)
  ) u_head_ram (
    .clk   (clk),
    .we    (hd_we),
    .waddr (hd_waddr),
    .wdata (hd_wdata),
    .raddr (hd_raddr),
    .rdata (hd_rdata)
  );

  chm_ram #(
    .DEPTH (NODES),
    .WIDTH (NWW)
  ) u_node_ram (
    .clk   (clk),
    .we    (nd_we),
    .waddr (nd_waddr),
    .wdata (nd_wdata),
    .raddr (nd_raddr),
    .rdata (nd_rdata)
  );

endmodule

`default_nettype wire

// File: design/chm_checker.sv
// ---------------------------------------------------------------------------
// chm_checker
// Port-level checks on the result channel of the chained hash map engine.
// ---------------------------------------------------------------------------
`default_nettype none

`include "chained_hash_map_engine_macros.svh"

module chm_checker import chm_pkg::*; #(
  parameter int NODES = CHM_NODES
) (
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata
);

  logic              r_found;
  logic              r_full;
  logic [DATA_W-1:0] r_prev;
  logic [COUNT_W-1:0] r_count;

  assign r_found = out_tdata[OUT_FOUND_LSB];
  assign r_full  = out_tdata[OUT_FULL_LSB];
  assign r_prev  = out_tdata[OUT_PREV_LSB +: DATA_W];
  assign r_count = out_tdata[OUT_COUNT_LSB +: COUNT_W];

  `CHM_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result beat changed while stalled")
  `CHM_ASSERT_IMP(a_count_range, out_tvalid, r_count <= COUNT_W'(NODES), "entry count above pool size")
  `CHM_ASSERT_IMP(a_full_count, out_tvalid && r_full, r_count == COUNT_W'(NODES) && !r_found, "full flag without a full pool")
  `CHM_ASSERT_IMP(a_absent_zero, out_tvalid && !r_found, r_prev == '0, "previous value nonzero for an absent key")

endmodule

bind chained_hash_map_engine chm_checker #(
  .NODES (NODES)
) u_chm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
